@@ hw/rtl/yuvfx_pkg.sv @@
// ----------------------------------------------------------------------------
// YUV frame effects package
// Shared constants, register indexes, effect codes and interface structs.
// ----------------------------------------------------------------------------
package yuvfx_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_RAW_W  = 13;
    localparam int GAIN_W     = 12;
    localparam int BORDER_W   = 13;
    localparam int SAMPLE_W   = 8;
    localparam int PLANE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_FORMAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH  = 3'd5;

    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    localparam logic [SAMPLE_W-1:0] PIX_MID = 8'd128;
    localparam logic [SAMPLE_W-1:0] PIX_MAX = 8'd255;

    localparam int DIM_RESET = 256;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 12'd256;
    localparam logic [BORDER_W-1:0] BORDER_RESET = 13'd20;

    typedef enum logic [1:0] {
        FX_PASS   = 2'd0,
        FX_GRAY   = 2'd1,
        FX_GAIN   = 2'd2,
        FX_BORDER = 2'd3
    } fx_mode_t;

    typedef struct packed {
        logic                chroma_444;
        fx_mode_t            effect_mode;
        logic [GAIN_W-1:0]   luma_gain;
        logic [BORDER_W-1:0] border_width;
    } fx_cfg_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic               frame_end;
    } px_tag_t;

endpackage

@@ hw/rtl/yuv_planar_frame_effects_top.sv @@
// ----------------------------------------------------------------------------
// YUV planar frame effects
// Per-byte effect processor for planar 4:2:0 / 4:4:4 YUV frame streams.
//
//   Channel  Direction  Ports                                    Width
//   s_       in         s_valid s_ready s_sample                 8
//   m_       out        m_valid m_ready m_pixel m_plane m_frame_end  8/2/1
//   cfg_     in         cfg_valid cfg_ready cfg_index cfg_wdata  3/13
//
// One transaction per clock in each direction while the result channel is
// not stalled. An accepted input transaction is registered in the input
// stage and then in the result register before it is valid on the result
// channel. Reset is synchronous, active low, and returns the position to
// the first Y byte with the registers at their defaults. A stalled result
// holds its register while the input stage still takes one more transaction.
// ----------------------------------------------------------------------------
module yuv_planar_frame_effects_top #(
    parameter int MAX_DIM = yuvfx_pkg::MAX_DIM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yuvfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yuvfx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [yuvfx_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [yuvfx_pkg::SAMPLE_W-1:0]   m_pixel,
    output logic [yuvfx_pkg::PLANE_W-1:0]    m_plane,
    output logic                             m_frame_end
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [DIM_W-1:0]               frame_w;
    logic [DIM_W-1:0]               frame_h;
    yuvfx_pkg::fx_cfg_t             fx_cfg;
    logic                           down_ready;
    logic                           s1_valid;
    logic [yuvfx_pkg::SAMPLE_W-1:0] s1_sample;
    logic [CNT_W-1:0]               s1_row;
    logic [CNT_W-1:0]               s1_col;
    yuvfx_pkg::px_tag_t             s1_tag;

    yuvfx_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .fx_cfg    (fx_cfg)
    );

    yuvfx_pos #(.MAX_DIM(MAX_DIM)) u_pos (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .frame_w    (frame_w),
        .frame_h    (frame_h),
        .chroma_444 (fx_cfg.chroma_444),
        .down_ready (down_ready),
        .s1_valid   (s1_valid),
        .s1_sample  (s1_sample),
        .s1_row     (s1_row),
        .s1_col     (s1_col),
        .s1_tag     (s1_tag)
    );

    yuvfx_fx #(.MAX_DIM(MAX_DIM)) u_fx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_valid    (s1_valid),
        .s1_sample   (s1_sample),
        .s1_row      (s1_row),
        .s1_col      (s1_col),
        .s1_tag      (s1_tag),
        .frame_w     (frame_w),
        .frame_h     (frame_h),
        .fx_cfg      (fx_cfg),
        .down_ready  (down_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel     (m_pixel),
        .m_plane     (m_plane),
        .m_frame_end (m_frame_end)
    );

endmodule

@@ hw/rtl/yuvfx_cfg.sv @@
// ----------------------------------------------------------------------------
// YUV frame effects configuration registers
// Holds the six control registers; frame dimensions are clamped on write.
// ----------------------------------------------------------------------------
module yuvfx_cfg #(
    parameter int MAX_DIM = yuvfx_pkg::MAX_DIM_DEF,
    localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yuvfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yuvfx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [DIM_W-1:0]                 frame_w,
    output logic [DIM_W-1:0]                 frame_h,
    output yuvfx_pkg::fx_cfg_t               fx_cfg
);

    localparam int CMP_W   = (DIM_W > yuvfx_pkg::DIM_RAW_W) ? DIM_W : yuvfx_pkg::DIM_RAW_W;
    localparam int DIM_RST = (yuvfx_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : yuvfx_pkg::DIM_RESET;

    logic [DIM_W-1:0]               frame_w_reg;
    logic [DIM_W-1:0]               frame_h_reg;
    logic                           chroma_reg;
    yuvfx_pkg::fx_mode_t            mode_reg;
    logic [yuvfx_pkg::GAIN_W-1:0]   gain_reg;
    logic [yuvfx_pkg::BORDER_W-1:0] border_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [yuvfx_pkg::DIM_RAW_W-1:0] raw);
        logic [CMP_W-1:0] v;
        v = CMP_W'(raw);
        if (v < CMP_W'(2)) begin
            v = CMP_W'(2);
        end else if (v > CMP_W'(MAX_DIM)) begin
            v = CMP_W'(MAX_DIM);
        end
        return v[DIM_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg <= DIM_W'(DIM_RST);
            frame_h_reg <= DIM_W'(DIM_RST);
            chroma_reg  <= 1'b0;
            mode_reg    <= yuvfx_pkg::FX_PASS;
            gain_reg    <= yuvfx_pkg::GAIN_RESET;
            border_reg  <= yuvfx_pkg::BORDER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                yuvfx_pkg::REG_FRAME_WIDTH: begin
                    frame_w_reg <= clamp_dim(cfg_wdata[yuvfx_pkg::DIM_RAW_W-1:0]);
                end
                yuvfx_pkg::REG_FRAME_HEIGHT: begin
                    frame_h_reg <= clamp_dim(cfg_wdata[yuvfx_pkg::DIM_RAW_W-1:0]);
                end
                yuvfx_pkg::REG_CHROMA_FORMAT: begin
                    chroma_reg <= cfg_wdata[0];
                end
                yuvfx_pkg::REG_EFFECT_MODE: begin
                    mode_reg <= yuvfx_pkg::fx_mode_t'(cfg_wdata[1:0]);
                end
                yuvfx_pkg::REG_LUMA_GAIN: begin
                    gain_reg <= cfg_wdata[yuvfx_pkg::GAIN_W-1:0];
                end
                yuvfx_pkg::REG_BORDER_WIDTH: begin
                    border_reg <= cfg_wdata[yuvfx_pkg::BORDER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign frame_w             = frame_w_reg;
    assign frame_h             = frame_h_reg;
    assign fx_cfg.chroma_444   = chroma_reg;
    assign fx_cfg.effect_mode  = mode_reg;
    assign fx_cfg.luma_gain    = gain_reg;
    assign fx_cfg.border_width = border_reg;

endmodule

@@ hw/rtl/yuvfx_pos.sv @@
// ----------------------------------------------------------------------------
// YUV frame effects position tracker
// Tracks plane, row and column, and registers each accepted byte with its tag.
// ----------------------------------------------------------------------------
module yuvfx_pos #(
    parameter int MAX_DIM = yuvfx_pkg::MAX_DIM_DEF,
    localparam int DIM_W = $clog2(MAX_DIM + 1),
    localparam int CNT_W = $clog2(MAX_DIM)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [yuvfx_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [DIM_W-1:0]               frame_w,
    input  logic [DIM_W-1:0]               frame_h,
    input  logic                           chroma_444,
    input  logic                           down_ready,
    output logic                           s1_valid,
    output logic [yuvfx_pkg::SAMPLE_W-1:0] s1_sample,
    output logic [CNT_W-1:0]               s1_row,
    output logic [CNT_W-1:0]               s1_col,
    output yuvfx_pkg::px_tag_t             s1_tag
);

    logic [yuvfx_pkg::PLANE_W-1:0] plane_reg;
    logic [yuvfx_pkg::PLANE_W-1:0] plane_next;
    logic [CNT_W-1:0]              row_reg;
    logic [CNT_W-1:0]              row_next;
    logic [CNT_W-1:0]              col_reg;
    logic [CNT_W-1:0]              col_next;
    logic [yuvfx_pkg::PLANE_W-1:0] plane_cur;
    logic [DIM_W-1:0]              plane_w;
    logic [DIM_W-1:0]              plane_h;
    logic [CNT_W:0]                col_inc;
    logic [CNT_W:0]                row_inc;
    logic                          row_wrap;
    logic                          plane_wrap;
    logic                          last;
    logic                          accept;

    logic                           s1_valid_reg;
    logic [yuvfx_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic [CNT_W-1:0]               s1_row_reg;
    logic [CNT_W-1:0]               s1_col_reg;
    yuvfx_pkg::px_tag_t             s1_tag_reg;

    always_comb begin
        plane_cur = (plane_reg > yuvfx_pkg::PLANE_V) ? yuvfx_pkg::PLANE_Y : plane_reg;
        if (plane_cur != yuvfx_pkg::PLANE_Y && !chroma_444) begin
            plane_w = frame_w >> 1;
            plane_h = frame_h >> 1;
        end else begin
            plane_w = frame_w;
            plane_h = frame_h;
        end
        col_inc    = {1'b0, col_reg} + (CNT_W+1)'(1);
        row_inc    = {1'b0, row_reg} + (CNT_W+1)'(1);
        row_wrap   = col_inc >= (CNT_W+1)'(plane_w);
        plane_wrap = row_wrap && (row_inc >= (CNT_W+1)'(plane_h));
        last       = plane_wrap && (plane_cur == yuvfx_pkg::PLANE_V);

        col_next   = row_wrap ? '0 : col_inc[CNT_W-1:0];
        row_next   = row_reg;
        plane_next = plane_cur;
        if (row_wrap) begin
            row_next = plane_wrap ? '0 : row_inc[CNT_W-1:0];
        end
        if (plane_wrap) begin
            plane_next = last ? yuvfx_pkg::PLANE_Y : plane_cur + 2'd1;
        end
    end

    assign s_ready = !s1_valid_reg || down_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg    <= yuvfx_pkg::PLANE_Y;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                plane_reg    <= plane_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                s1_valid_reg <= 1'b1;
            end else if (down_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg        <= s_sample;
            s1_row_reg           <= row_reg;
            s1_col_reg           <= col_reg;
            s1_tag_reg.plane     <= plane_cur;
            s1_tag_reg.frame_end <= last;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_sample = s1_sample_reg;
    assign s1_row    = s1_row_reg;
    assign s1_col    = s1_col_reg;
    assign s1_tag    = s1_tag_reg;

    a_plane_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        plane_reg != 2'd3)
        else $error("plane counter left the Y/U/V range");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last |=> plane_reg == yuvfx_pkg::PLANE_Y && row_reg == '0 && col_reg == '0)
        else $error("frame end did not restart the position at the Y plane origin");

endmodule

@@ hw/rtl/yuvfx_fx.sv @@
// ----------------------------------------------------------------------------
// YUV frame effects pixel unit
// Applies the selected effect to the staged byte and holds the result register.
// ----------------------------------------------------------------------------
module yuvfx_fx #(
    parameter int MAX_DIM = yuvfx_pkg::MAX_DIM_DEF,
    localparam int DIM_W = $clog2(MAX_DIM + 1),
    localparam int CNT_W = $clog2(MAX_DIM)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s1_valid,
    input  logic [yuvfx_pkg::SAMPLE_W-1:0] s1_sample,
    input  logic [CNT_W-1:0]               s1_row,
    input  logic [CNT_W-1:0]               s1_col,
    input  yuvfx_pkg::px_tag_t             s1_tag,
    input  logic [DIM_W-1:0]               frame_w,
    input  logic [DIM_W-1:0]               frame_h,
    input  yuvfx_pkg::fx_cfg_t             fx_cfg,
    output logic                           down_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [yuvfx_pkg::SAMPLE_W-1:0] m_pixel,
    output logic [yuvfx_pkg::PLANE_W-1:0]  m_plane,
    output logic                           m_frame_end
);

    localparam int SW = ((DIM_W > yuvfx_pkg::BORDER_W) ? DIM_W : yuvfx_pkg::BORDER_W) + 2;
    localparam int PROD_W = yuvfx_pkg::SAMPLE_W + yuvfx_pkg::GAIN_W;

    logic signed [SW-1:0]           ii;
    logic signed [SW-1:0]           jj;
    logic signed [SW-1:0]           ww;
    logic signed [SW-1:0]           hh;
    logic signed [SW-1:0]           bb;
    logic signed [SW-1:0]           hbb;
    logic                           in_band;
    logic                           in_outer;
    logic [PROD_W-1:0]              prod;
    logic [yuvfx_pkg::GAIN_W-1:0]   scaled;
    logic [yuvfx_pkg::SAMPLE_W-1:0] gain_pix;
    logic [yuvfx_pkg::SAMPLE_W-1:0] border_pix;
    logic [yuvfx_pkg::SAMPLE_W-1:0] pixel_next;
    logic                           is_luma;
    logic                           load;

    logic                           m_valid_reg;
    logic [yuvfx_pkg::SAMPLE_W-1:0] m_pixel_reg;
    yuvfx_pkg::px_tag_t             m_tag_reg;

    always_comb begin
        ii  = $signed(SW'(s1_row));
        jj  = $signed(SW'(s1_col));
        ww  = $signed(SW'(frame_w));
        hh  = $signed(SW'(frame_h));
        bb  = $signed(SW'(fx_cfg.border_width));
        hbb = bb >>> 1;
        in_band  = (jj < bb) || (jj > ww - bb) || (ii < bb) || (ii > hh - bb);
        in_outer = (jj < hbb) || (jj > ww - hbb) || (ii < hbb) || (ii > hh - hbb);
        if (in_outer) begin
            border_pix = yuvfx_pkg::PIX_MID;
        end else if (in_band) begin
            border_pix = yuvfx_pkg::PIX_MAX;
        end else begin
            border_pix = s1_sample;
        end

        prod     = PROD_W'(s1_sample) * PROD_W'(fx_cfg.luma_gain);
        scaled   = prod[PROD_W-1:8];
        gain_pix = (|scaled[yuvfx_pkg::GAIN_W-1:8]) ? yuvfx_pkg::PIX_MAX : scaled[7:0];

        is_luma    = s1_tag.plane == yuvfx_pkg::PLANE_Y;
        pixel_next = s1_sample;
        case (fx_cfg.effect_mode)
            yuvfx_pkg::FX_PASS: begin
                pixel_next = s1_sample;
            end
            yuvfx_pkg::FX_GRAY: begin
                if (!is_luma) begin
                    pixel_next = yuvfx_pkg::PIX_MID;
                end
            end
            yuvfx_pkg::FX_GAIN: begin
                if (is_luma) begin
                    pixel_next = gain_pix;
                end
            end
            yuvfx_pkg::FX_BORDER: begin
                if (is_luma) begin
                    pixel_next = border_pix;
                end
            end
            default: begin
                pixel_next = s1_sample;
            end
        endcase
    end

    assign down_ready = !m_valid_reg || m_ready;
    assign load       = s1_valid && down_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_pixel_reg <= pixel_next;
            m_tag_reg   <= s1_tag;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel     = m_pixel_reg;
    assign m_plane     = m_tag_reg.plane;
    assign m_frame_end = m_tag_reg.frame_end;

    a_end_on_v: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_plane == yuvfx_pkg::PLANE_V)
        else $error("frame end flagged outside the V plane");

    a_gray_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        load && fx_cfg.effect_mode == yuvfx_pkg::FX_GRAY && !is_luma
        |=> m_pixel == yuvfx_pkg::PIX_MID)
        else $error("gray mode chroma byte is not mid level");

    a_pass_value: assert property (@(posedge aclk) disable iff (!aresetn)
        load && fx_cfg.effect_mode == yuvfx_pkg::FX_PASS |=> m_pixel == $past(s1_sample))
        else $error("pass mode altered the byte");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV planar frame effects testbench
// Streams planar frame bytes through the effect processor and checks every
// transaction on the result channel against an in-bench model of the plane,
// row and column tracking and of the four effects. Directed checks come first,
// then randomized frames and fragments under several flow-control patterns.
// ----------------------------------------------------------------------------
module tb;

    import yuvfx_pkg::*;

    localparam int MAX_DIM        = MAX_DIM_DEF;
    localparam int RESULT_LATENCY = 2;
    localparam int STALL_CYCLES   = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int BURST_CAP      = 250;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic [PLANE_W-1:0]  plane;
        logic                frame_end;
    } pixel_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SAMPLE_W-1:0]   m_pixel;
    logic [PLANE_W-1:0]    m_plane;
    logic                  m_frame_end;

    logic [DIM_RAW_W-1:0] cfg_width;
    logic [DIM_RAW_W-1:0] cfg_height;
    logic                 cfg_chroma444;
    fx_mode_t             cfg_mode;
    logic [GAIN_W-1:0]    cfg_gain;
    logic [BORDER_W-1:0]  cfg_border;
    logic [PLANE_W-1:0]   pos_plane;
    int                   pos_row;
    int                   pos_col;

    pixel_result_t pixel_expect_q[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            cycle_count = 0;
    int            rx_hold_left = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;

    yuv_planar_frame_effects_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel     (m_pixel),
        .m_plane     (m_plane),
        .m_frame_end (m_frame_end)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[yuv_planar_frame_effects_top] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch in result %0d, %s: got %0d, expected %0d",
                     results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_expect_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_pixel, 0);
            end else begin
                want = pixel_expect_q.pop_front();
                if (m_pixel !== want.pixel) begin
                    report_mismatch("pixel", m_pixel, want.pixel);
                end
                if (m_plane !== want.plane) begin
                    report_mismatch("plane", m_plane, want.plane);
                end
                if (m_frame_end !== want.frame_end) begin
                    report_mismatch("frame_end", m_frame_end, want.frame_end);
                end
            end
            results_seen++;
        end
    end

    function automatic int clamp_dim(input logic [DIM_RAW_W-1:0] raw);
        if (raw < 2) begin
            return 2;
        end
        if (raw > MAX_DIM) begin
            return MAX_DIM;
        end
        return raw;
    endfunction

    task automatic reset_prediction();
        cfg_width     = DIM_RESET;
        cfg_height    = DIM_RESET;
        cfg_chroma444 = 1'b0;
        cfg_mode      = FX_PASS;
        cfg_gain      = GAIN_RESET;
        cfg_border    = BORDER_RESET;
        pos_plane     = PLANE_Y;
        pos_row       = 0;
        pos_col       = 0;
    endtask

    function automatic pixel_result_t predict_next_pixel(input logic [SAMPLE_W-1:0] smp);
        pixel_result_t      res;
        logic [PLANE_W-1:0] pl;
        int                 w;
        int                 h;
        int                 pw;
        int                 ph;
        int                 b;
        int                 hb;
        int                 gained;
        w  = clamp_dim(cfg_width);
        h  = clamp_dim(cfg_height);
        pl = (pos_plane > PLANE_V) ? PLANE_Y : pos_plane;
        if (pl != PLANE_Y && !cfg_chroma444) begin
            pw = w >> 1;
            ph = h >> 1;
        end else begin
            pw = w;
            ph = h;
        end
        res.pixel = smp;
        if (pl == PLANE_Y) begin
            if (cfg_mode == FX_GAIN) begin
                gained = smp;
                gained = (gained * cfg_gain) >> 8;
                res.pixel = (gained > 255) ? PIX_MAX : gained[SAMPLE_W-1:0];
            end else if (cfg_mode == FX_BORDER) begin
                b  = cfg_border;
                hb = b / 2;
                if (pos_col < b || pos_col > w - b || pos_row < b || pos_row > h - b) begin
                    res.pixel = PIX_MAX;
                end
                if (pos_col < hb || pos_col > w - hb || pos_row < hb || pos_row > h - hb) begin
                    res.pixel = PIX_MID;
                end
            end
        end else if (cfg_mode == FX_GRAY) begin
            res.pixel = PIX_MID;
        end
        res.plane     = pl;
        res.frame_end = 1'b0;
        if (pos_col + 1 >= pw) begin
            pos_col = 0;
            if (pos_row + 1 >= ph) begin
                pos_row = 0;
                if (pl == PLANE_V) begin
                    res.frame_end = 1'b1;
                    pos_plane = PLANE_Y;
                end else begin
                    pos_plane = pl + 1'b1;
                end
            end else begin
                pos_row++;
                pos_plane = pl;
            end
        end else begin
            pos_col++;
            pos_plane = pl;
        end
        return res;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pixel_expect_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:   cfg_width = data;
            REG_FRAME_HEIGHT:  cfg_height = data;
            REG_CHROMA_FORMAT: cfg_chroma444 = data[0];
            REG_EFFECT_MODE:   cfg_mode = fx_mode_t'(data[1:0]);
            REG_LUMA_GAIN:     cfg_gain = data[GAIN_W-1:0];
            REG_BORDER_WIDTH:  cfg_border = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, output logic at_frame_end);
        pixel_result_t want;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        want = predict_next_pixel(smp);
        pixel_expect_q.push_back(want);
        at_frame_end = want.frame_end;
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_list(input logic [SAMPLE_W-1:0] samples[]);
        logic fe;
        foreach (samples[k]) begin
            send_sample(samples[k], fe);
        end
    endtask

    task automatic test_reset_defaults();
        send_list('{8'h00, 8'hFF, 8'h5A, 8'hA5});
    endtask

    // The column left over from the default width wraps once the width shrinks.
    task automatic test_gray_chroma();
        write_reg(REG_CHROMA_FORMAT, 13'd0);
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        write_reg(REG_EFFECT_MODE, 13'(FX_GRAY));
        send_list('{8'hC3, 8'h3C, 8'hFF, 8'h00});
    endtask

    task automatic test_luma_gain();
        write_reg(REG_EFFECT_MODE, 13'(FX_GAIN));
        write_reg(REG_LUMA_GAIN, 13'h0FFF);
        send_list('{8'hFF, 8'h01, 8'h80, 8'h00, 8'h7E, 8'h81});
        write_reg(REG_LUMA_GAIN, 13'd0);
        send_list('{8'hFF});
    endtask

    task automatic test_luma_border();
        write_reg(REG_CHROMA_FORMAT, 13'd1);
        write_reg(REG_FRAME_WIDTH, 13'd4);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        write_reg(REG_BORDER_WIDTH, 13'd2);
        write_reg(REG_EFFECT_MODE, 13'(FX_BORDER));
        send_list('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88});
    endtask

    // Widths below two are raised to two, and odd 4:2:0 chroma sizes round down.
    task automatic test_dimension_limits();
        write_reg(REG_CHROMA_FORMAT, 13'd0);
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        write_reg(REG_SPARE_LO, 13'h1FFF);
        write_reg(REG_SPARE_HI, 13'h0155);
        send_list('{8'h96, 8'h69});
    endtask

    task automatic test_output_stall();
        logic fe;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_FRAME_WIDTH, 13'd6);
        write_reg(REG_FRAME_HEIGHT, 13'd4);
        write_reg(REG_EFFECT_MODE, 13'(FX_GAIN));
        write_reg(REG_LUMA_GAIN, 13'd300);
        rx_hold_left = STALL_CYCLES;
        repeat (40) begin
            send_sample(8'($urandom_range(255)), fe);
        end
        wait_drained();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 13'd0;
                    1: return 13'd4096;
                    2: return 13'd4097;
                    default: return 13'h1FFF;
                endcase
            end
            1: return 13'($urandom_range(8191));
            default: return 13'($urandom_range(1, 9));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'h0FFF;
            2: return 13'(GAIN_RESET);
            default: return 13'($urandom_range(8191));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_border();
        case ($urandom_range(9))
            0: return 13'd4096;
            1: return 13'h1FFF;
            2, 3: return 13'($urandom_range(8191));
            default: return 13'($urandom_range(5));
        endcase
    endfunction

    task automatic randomize_settings();
        if ($urandom_range(1)) write_reg(REG_FRAME_WIDTH, pick_dim());
        if ($urandom_range(1)) write_reg(REG_FRAME_HEIGHT, pick_dim());
        if ($urandom_range(1)) write_reg(REG_CHROMA_FORMAT, 13'($urandom_range(8191)));
        if ($urandom_range(4) != 0) write_reg(REG_EFFECT_MODE, 13'($urandom_range(8191)));
        if ($urandom_range(1)) write_reg(REG_LUMA_GAIN, pick_gain());
        if ($urandom_range(1)) write_reg(REG_BORDER_WIDTH, pick_border());
        if ($urandom_range(9) == 0) begin
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                      13'($urandom_range(8191)));
        end
    endtask

    // Mostly whole frames with random content; some bursts stop mid-frame so
    // that the next settings take effect with the position counters kept.
    task automatic test_random_traffic(input int unsigned tx_idle, input int unsigned rx_idle,
                                       input int n_items);
        int   sent;
        int   n;
        int   cap;
        int   goal;
        int   ends;
        logic fe;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        sent = 0;
        while (sent < n_items) begin
            randomize_settings();
            goal = $urandom_range(1, 2);
            cap  = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : BURST_CAP;
            n    = 0;
            ends = 0;
            while (n < cap && ends < goal) begin
                send_sample(8'($urandom_range(255)), fe);
                n++;
                ends += fe;
            end
            sent += n;
        end
        wait_drained();
    endtask

    initial begin
        reset_prediction();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_gray_chroma();
        test_luma_gain();
        test_luma_border();
        test_dimension_limits();
        test_output_stall();
        test_random_traffic(31, 65, 430);
        test_random_traffic(65, 31, 430);
        test_random_traffic(0, 0, 430);
        wait_drained();
        repeat (RESULT_LATENCY + 8) @(posedge aclk);
        if (pixel_expect_q.size() != 0) begin
            report_mismatch("results missing", 0, pixel_expect_q.size());
        end
        if (mismatch_count == 0) begin
            $display("[yuv_planar_frame_effects_top] OK");
        end else begin
            $display("[yuv_planar_frame_effects_top] ERROR");
        end
        $finish;
    end

endmodule
